### hw/rtl/lte_pkg.sv
// shared types and constants for the lifetime expiry table
package lte_pkg;

  localparam logic [2:0] FN_REG_ABS = 3'd0;
  localparam logic [2:0] FN_REG_REL = 3'd1;
  localparam logic [2:0] FN_UNREG   = 3'd2;
  localparam logic [2:0] FN_CLEAR   = 3'd3;
  localparam logic [2:0] FN_TICK    = 3'd4;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_FULL    = 1'b1;

  localparam int MAX_RESULTS = 64;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] object_id;
    logic [63:0] time_ms;
    logic [31:0] lifetime_ms;
  } lte_in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] expired_id;
    logic        last;
  } lte_out_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_REMOVE,
    OP_TICK,
    OP_CLEAR
  } lte_op_t;

  typedef struct packed {
    lte_op_t     op;
    logic [31:0] id;
    logic [63:0] value;
  } lte_cmd_t;

  typedef struct packed {
    logic        used;
    logic [31:0] obj;
    logic [63:0] expiry;
  } lte_slot_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } lte_bk_state_t;

endpackage

### hw/rtl/lifetime_expiry_table.sv
// top level of the lifetime expiry table
// Usage: the in_ channel carries commands (register absolute, register relative,
// unregister, clear, tick); the out_ channel carries expired-object and
// table-full results, with last marking the final result of a command.
// Register and unregister commands with id zero, and unused func codes, are
// dropped in the front end. A command passes a front register and a
// four-entry queue; then, but for a clear, the back end reads every one of the
// CAPACITY slots through the single read port of the slot memory, one slot per
// cycle while no stalled result holds the scan. A clear sweeps the slot memory
// at one slot per cycle. A tick returns up to 64 results, in slot order, the
// last of them after its scan ends.
// After reset the same clearing pass runs, and in_ready stays low until it
// ends. A stalled receiver holds the result in the output register; the scan
// waits at the next expired slot, while the front end keeps accepting
// commands until the queue is full.
module lifetime_expiry_table import lte_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lte_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lte_out_t out_data
);

  logic     init_busy;
  logic     f_valid, f_ready;
  lte_cmd_t f_data;
  logic     q_valid, q_ready;
  lte_cmd_t q_data;

  lte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_busy (init_busy),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  lte_fifo #(
    .WIDTH ($bits(lte_cmd_t)),
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lte_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/lte_ram.sv
// generic single write port ram with registered read
module lte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/lte_front.sv
// front end: accepts input transactions and classifies them into commands
module lte_front import lte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lte_in_t  in_data,
  input  logic     init_busy,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output lte_cmd_t cmd_data
);

  logic     cmd_vld_r, cmd_vld_nxt;
  lte_cmd_t cmd_r, cmd_nxt;
  lte_cmd_t cls;
  logic     keep;
  logic     take;
  logic [64:0] sum;
  logic [63:0] sat;

  assign in_ready = !init_busy && (!cmd_vld_r || cmd_ready);
  assign take     = in_valid && in_ready;

  // saturating now + lifetime
  assign sum = {1'b0, in_data.time_ms} + {33'b0, in_data.lifetime_ms};
  assign sat = sum[64] ? {64{1'b1}} : sum[63:0];

  always_comb begin
    keep      = 1'b0;
    cls.op    = OP_TICK;
    cls.id    = in_data.object_id;
    cls.value = in_data.time_ms;
    case (in_data.func)
      FN_REG_ABS: begin
        keep   = in_data.object_id != 32'd0;
        cls.op = (in_data.time_ms == 64'd0) ? OP_REMOVE : OP_STORE;
      end
      FN_REG_REL: begin
        keep      = in_data.object_id != 32'd0;
        cls.op    = (in_data.lifetime_ms == 32'd0) ? OP_REMOVE : OP_STORE;
        cls.value = sat;
      end
      FN_UNREG: begin
        keep   = in_data.object_id != 32'd0;
        cls.op = OP_REMOVE;
      end
      FN_CLEAR: begin
        keep   = 1'b1;
        cls.op = OP_CLEAR;
      end
      FN_TICK: begin
        keep   = 1'b1;
        cls.op = OP_TICK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    cmd_nxt     = cmd_r;
    if (cmd_ready) begin
      cmd_vld_nxt = 1'b0;
    end
    if (take && keep) begin
      cmd_vld_nxt = 1'b1;
      cmd_nxt     = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = cmd_vld_r;
  assign cmd_data  = cmd_r;

endmodule

### hw/rtl/lte_fifo.sv
// small command queue between front end and back end
module lte_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign push_ready = cnt_r != DEPTH_C;
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST_C) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_C) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### hw/rtl/lte_back.sv
// back end: scans (or, for a clear, sweeps) the slot table for each command and drives results
module lte_back import lte_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  lte_cmd_t q_data,
  output logic     init_busy,
  output logic     out_valid,
  input  logic     out_ready,
  output lte_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);
  localparam logic [NW-1:0] MAX_C  = NW'(MAX_RESULTS);

  lte_bk_state_t state_r, state_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic [AW-1:0] ev_addr_r, ev_addr_nxt;
  lte_cmd_t      cmd_r, cmd_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [31:0]   pend_id_r, pend_id_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          mfound_r, mfound_nxt;
  logic [AW-1:0] maddr_r, maddr_nxt;
  logic [63:0]   mexp_r, mexp_nxt;
  logic          ffound_r, ffound_nxt;
  logic [AW-1:0] faddr_r, faddr_nxt;
  logic          out_vld_r, out_vld_nxt;
  lte_out_t      out_r, out_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  lte_slot_t     ram_wdata, rd;

  logic out_free, tick_hit, stall, adv, scan_end, done_ok, push;
  lte_out_t push_data;

  lte_ram #(
    .WIDTH ($bits(lte_slot_t)),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign out_free = !out_vld_r || out_ready;
  assign tick_hit = (cmd_r.op == OP_TICK) && rd.used && (rd.expiry != 64'd0) &&
                    (cmd_r.value >= rd.expiry) && (n_r < MAX_C);
  assign stall    = tick_hit && pend_vld_r && !out_free;
  assign adv      = ev_vld_r && !stall;
  assign scan_end = (iss_r == CAP_C) && !ev_vld_r;
  assign done_ok  = out_free ||
                    !((cmd_r.op == OP_TICK && pend_vld_r) ||
                      (cmd_r.op == OP_STORE && !mfound_r && !ffound_r));

  assign q_ready   = state_r == BK_IDLE;
  assign init_busy = state_r == BK_CLEAR;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (iss_r == LAST_C) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_data.op == OP_CLEAR) ? BK_CLEAR : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (done_ok) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    iss_nxt      = iss_r;
    ev_vld_nxt   = ev_vld_r;
    ev_addr_nxt  = ev_addr_r;
    cmd_nxt      = cmd_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    n_nxt        = n_r;
    mfound_nxt   = mfound_r;
    maddr_nxt    = maddr_r;
    mexp_nxt     = mexp_r;
    ffound_nxt   = ffound_r;
    faddr_nxt    = faddr_r;
    ram_we       = 1'b0;
    ram_waddr    = iss_r[AW-1:0];
    ram_wdata    = rd;
    ram_re       = 1'b0;
    ram_raddr    = iss_r[AW-1:0];
    push         = 1'b0;
    push_data    = '{kind: KIND_EXPIRED, expired_id: pend_id_r, last: 1'b0};
    case (state_r)
      BK_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = iss_r[AW-1:0];
        ram_wdata      = '0;
        iss_nxt        = iss_r + 1'b1;
      end
      BK_IDLE: begin
        iss_nxt      = '0;
        ev_vld_nxt   = 1'b0;
        pend_vld_nxt = 1'b0;
        n_nxt        = '0;
        mfound_nxt   = 1'b0;
        ffound_nxt   = 1'b0;
        if (q_valid) begin
          cmd_nxt = q_data;
        end
      end
      BK_SCAN: begin
        if (adv) begin
          if (cmd_r.op == OP_TICK) begin
            if (tick_hit) begin
              if (pend_vld_r) begin
                push = 1'b0 || 1'b1;
              end
              pend_vld_nxt = 1'b1;
              pend_id_nxt  = rd.obj;
              n_nxt        = n_r + 1'b1;
              ram_we       = 1'b1;
              ram_waddr    = ev_addr_r;
              ram_wdata    = '{used: 1'b0, obj: rd.obj, expiry: rd.expiry};
            end
          end else begin
            if (rd.used && (rd.obj == cmd_r.id) && !mfound_r) begin
              mfound_nxt = 1'b1;
              maddr_nxt  = ev_addr_r;
              mexp_nxt   = rd.expiry;
            end
            if (!rd.used && !ffound_r) begin
              ffound_nxt = 1'b1;
              faddr_nxt  = ev_addr_r;
            end
          end
        end
        if ((!ev_vld_r || adv) && (iss_r < CAP_C)) begin
          ram_re      = 1'b1;
          ram_raddr   = iss_r[AW-1:0];
          iss_nxt     = iss_r + 1'b1;
          ev_vld_nxt  = 1'b1;
          ev_addr_nxt = iss_r[AW-1:0];
        end else if (adv) begin
          ev_vld_nxt = 1'b0;
        end
      end
      BK_DONE: begin
        case (cmd_r.op)
          OP_TICK: begin
            if (pend_vld_r && out_free) begin
              push         = 1'b1;
              push_data    = '{kind: KIND_EXPIRED, expired_id: pend_id_r, last: 1'b1};
              pend_vld_nxt = 1'b0;
            end
          end
          OP_STORE: begin
            if (mfound_r) begin
              ram_we    = 1'b1;
              ram_waddr = maddr_r;
              ram_wdata = '{used: 1'b1, obj: cmd_r.id,
                            expiry: (cmd_r.value > mexp_r) ? cmd_r.value : mexp_r};
            end else if (ffound_r) begin
              ram_we    = 1'b1;
              ram_waddr = faddr_r;
              ram_wdata = '{used: 1'b1, obj: cmd_r.id, expiry: cmd_r.value};
            end else if (out_free) begin
              push      = 1'b1;
              push_data = '{kind: KIND_FULL, expired_id: cmd_r.id, last: 1'b1};
            end
          end
          OP_REMOVE: begin
            if (mfound_r) begin
              ram_we    = 1'b1;
              ram_waddr = maddr_r;
              ram_wdata = '{used: 1'b0, obj: cmd_r.id, expiry: mexp_r};
            end
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (push) begin
      out_vld_nxt = 1'b1;
      out_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      iss_r      <= '0;
      ev_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      n_r        <= '0;
      mfound_r   <= 1'b0;
      ffound_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_r      <= iss_nxt;
      ev_vld_r   <= ev_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      n_r        <= n_nxt;
      mfound_r   <= mfound_nxt;
      ffound_r   <= ffound_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    ev_addr_r <= ev_addr_nxt;
    cmd_r     <= cmd_nxt;
    pend_id_r <= pend_id_nxt;
    maddr_r   <= maddr_nxt;
    mexp_r    <= mexp_nxt;
    faddr_r   <= faddr_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_C)
    else $error("tick result count above limit");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> (state_r == BK_SCAN))
    else $error("slot evaluation outside scan");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_vld_r || out_ready))
    else $error("result overwrote a waiting transaction");

endmodule
